// ----- src/bps_pkg.sv -----
package bps_pkg;

	// fixed field widths
	localparam int NORMAL_BITS = 16;
	localparam int KIND_BITS   = 3;
	localparam int SIDE_BITS   = 2;
	localparam int AXES        = 3;

	// default parameter values
	localparam int COORD_BITS_DEF       = 32;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// plane kinds below this count are axial
	localparam logic [KIND_BITS-1:0] AXIAL_KINDS = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_X      = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_Y      = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_Z      = 3'd2;

	// result codes
	localparam logic [SIDE_BITS-1:0] SIDE_NONE  = 2'b00;
	localparam logic [SIDE_BITS-1:0] SIDE_FRONT = 2'b01;
	localparam logic [SIDE_BITS-1:0] SIDE_BACK  = 2'b10;
	localparam logic [SIDE_BITS-1:0] SIDE_BOTH  = 2'b11;

endpackage

// ----- src/box_plane_side_top.sv -----
// box against plane classification, fully pipelined
// four register stages from input request accepted to result valid: select, multiply,
// sum, compare; throughput: one request per cycle while the output is not stalled
// all six products and both sums each fit in one stage
// output stalls back up stage by stage, bubbles are filled before input is held off
// reset clears only the stage valid bits; data registers are not reset
module box_plane_side_top #(
	parameter int COORD_BITS = bps_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = bps_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [COORD_BITS-1:0]           min_x,
	input  logic signed [COORD_BITS-1:0]           min_y,
	input  logic signed [COORD_BITS-1:0]           min_z,
	input  logic signed [COORD_BITS-1:0]           max_x,
	input  logic signed [COORD_BITS-1:0]           max_y,
	input  logic signed [COORD_BITS-1:0]           max_z,
	input  logic signed [bps_pkg::NORMAL_BITS-1:0] normal_x,
	input  logic signed [bps_pkg::NORMAL_BITS-1:0] normal_y,
	input  logic signed [bps_pkg::NORMAL_BITS-1:0] normal_z,
	input  logic signed [COORD_BITS-1:0]           plane_dist,
	input  logic [bps_pkg::KIND_BITS-1:0]          plane_kind,
	input  logic [bps_pkg::AXES-1:0]               sign_bits,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bps_pkg::SIDE_BITS-1:0]          sides
);
	import bps_pkg::*;

	localparam int PW = COORD_BITS + NORMAL_BITS;
	localparam int SW = PW + 2;
	localparam int DW = COORD_BITS + NORMAL_FRAC_BITS + 1;
	localparam int CW = (SW > DW) ? SW : DW;

	logic signed [COORD_BITS-1:0]  box_lo [AXES];
	logic signed [COORD_BITS-1:0]  box_hi [AXES];
	logic signed [NORMAL_BITS-1:0] nrm [AXES];

	logic                          v1, r1;
	logic signed [COORD_BITS-1:0]  near_s1 [AXES];
	logic signed [COORD_BITS-1:0]  far_s1 [AXES];
	logic signed [NORMAL_BITS-1:0] nrm_s1 [AXES];
	logic signed [COORD_BITS-1:0]  dist_s1;
	logic                          axial_s1;
	logic signed [COORD_BITS-1:0]  ax_lo_s1;
	logic signed [COORD_BITS-1:0]  ax_hi_s1;

	logic                          v2, r2;
	logic signed [PW-1:0]          pnear_s2 [AXES];
	logic signed [PW-1:0]          pfar_s2 [AXES];
	logic signed [COORD_BITS-1:0]  dist_s2;
	logic                          axial_s2;
	logic [SIDE_BITS-1:0]          ax_side_s2;

	logic                          v3, r3;
	logic signed [SW-1:0]          dnear_s3;
	logic signed [SW-1:0]          dfar_s3;
	logic signed [DW-1:0]          dshift_s3;
	logic                          axial_s3;
	logic [SIDE_BITS-1:0]          ax_side_s3;

	logic                          valid_s4;
	logic [SIDE_BITS-1:0]          sides_s4;
	logic [SIDE_BITS-1:0]          gen_side;

	assign box_lo = '{min_x, min_y, min_z};
	assign box_hi = '{max_x, max_y, max_z};
	assign nrm    = '{normal_x, normal_y, normal_z};

	bps_select #(
		.COORD_BITS(COORD_BITS)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.box_lo    (box_lo),
		.box_hi    (box_hi),
		.nrm       (nrm),
		.plane_dist(plane_dist),
		.kind      (plane_kind),
		.sign_bits (sign_bits),
		.out_valid (v1),
		.out_ready (r1),
		.near_s1   (near_s1),
		.far_s1    (far_s1),
		.nrm_s1    (nrm_s1),
		.dist_s1   (dist_s1),
		.axial_s1  (axial_s1),
		.ax_lo_s1  (ax_lo_s1),
		.ax_hi_s1  (ax_hi_s1)
	);

	bps_mult #(
		.COORD_BITS(COORD_BITS)
	) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.near_s1   (near_s1),
		.far_s1    (far_s1),
		.nrm_s1    (nrm_s1),
		.dist_s1   (dist_s1),
		.axial_s1  (axial_s1),
		.ax_lo_s1  (ax_lo_s1),
		.ax_hi_s1  (ax_hi_s1),
		.out_valid (v2),
		.out_ready (r2),
		.pnear_s2  (pnear_s2),
		.pfar_s2   (pfar_s2),
		.dist_s2   (dist_s2),
		.axial_s2  (axial_s2),
		.ax_side_s2(ax_side_s2)
	);

	bps_sum #(
		.COORD_BITS      (COORD_BITS),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.pnear_s2  (pnear_s2),
		.pfar_s2   (pfar_s2),
		.dist_s2   (dist_s2),
		.axial_s2  (axial_s2),
		.ax_side_s2(ax_side_s2),
		.out_valid (v3),
		.out_ready (r3),
		.dnear_s3  (dnear_s3),
		.dfar_s3   (dfar_s3),
		.dshift_s3 (dshift_s3),
		.axial_s3  (axial_s3),
		.ax_side_s3(ax_side_s3)
	);

	// general plane: near dot at or above distance is front, far dot below is back
	always_comb begin
		gen_side = SIDE_NONE;
		if (CW'(dnear_s3) >= CW'(dshift_s3)) begin
			gen_side = gen_side | SIDE_FRONT;
		end
		if (CW'(dfar_s3) < CW'(dshift_s3)) begin
			gen_side = gen_side | SIDE_BACK;
		end
	end

	assign r3 = !valid_s4 || out_ready;

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (r3) begin
			valid_s4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (v3 && r3) begin
			sides_s4 <= axial_s3 ? ax_side_s3 : gen_side;
		end
	end

	assign out_valid = valid_s4;
	assign sides     = sides_s4;

endmodule

// ----- src/bps_select.sv -----
module bps_select #(
	parameter int COORD_BITS = bps_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         box_lo [bps_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]         box_hi [bps_pkg::AXES],
	input  logic signed [bps_pkg::NORMAL_BITS-1:0] nrm [bps_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]         plane_dist,
	input  logic [bps_pkg::KIND_BITS-1:0]        kind,
	input  logic [bps_pkg::AXES-1:0]             sign_bits,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_BITS-1:0]         near_s1 [bps_pkg::AXES],
	output logic signed [COORD_BITS-1:0]         far_s1 [bps_pkg::AXES],
	output logic signed [bps_pkg::NORMAL_BITS-1:0] nrm_s1 [bps_pkg::AXES],
	output logic signed [COORD_BITS-1:0]         dist_s1,
	output logic                                 axial_s1,
	output logic signed [COORD_BITS-1:0]         ax_lo_s1,
	output logic signed [COORD_BITS-1:0]         ax_hi_s1
);
	import bps_pkg::*;

	logic                          valid_s1;
	logic signed [COORD_BITS-1:0]  ax_lo;
	logic signed [COORD_BITS-1:0]  ax_hi;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	// pick the box bounds on the plane's axis
	always_comb begin
		ax_lo = box_lo[0];
		ax_hi = box_hi[0];
		unique case (kind)
			KIND_X: begin
				ax_lo = box_lo[0];
				ax_hi = box_hi[0];
			end
			KIND_Y: begin
				ax_lo = box_lo[1];
				ax_hi = box_hi[1];
			end
			KIND_Z: begin
				ax_lo = box_lo[2];
				ax_hi = box_hi[2];
			end
			default: begin
				ax_lo = box_lo[0];
				ax_hi = box_hi[0];
			end
		endcase
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// near and far corners from the sign bits
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < AXES; i++) begin
				near_s1[i] <= sign_bits[i] ? box_lo[i] : box_hi[i];
				far_s1[i]  <= sign_bits[i] ? box_hi[i] : box_lo[i];
				nrm_s1[i]  <= nrm[i];
			end
			dist_s1  <= plane_dist;
			axial_s1 <= kind < AXIAL_KINDS;
			ax_lo_s1 <= ax_lo;
			ax_hi_s1 <= ax_hi;
		end
	end

endmodule

// ----- src/bps_mult.sv -----
module bps_mult #(
	parameter int COORD_BITS = bps_pkg::COORD_BITS_DEF,
	localparam int PW = COORD_BITS + bps_pkg::NORMAL_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         near_s1 [bps_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]         far_s1 [bps_pkg::AXES],
	input  logic signed [bps_pkg::NORMAL_BITS-1:0] nrm_s1 [bps_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]         dist_s1,
	input  logic                                 axial_s1,
	input  logic signed [COORD_BITS-1:0]         ax_lo_s1,
	input  logic signed [COORD_BITS-1:0]         ax_hi_s1,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [PW-1:0]                 pnear_s2 [bps_pkg::AXES],
	output logic signed [PW-1:0]                 pfar_s2 [bps_pkg::AXES],
	output logic signed [COORD_BITS-1:0]         dist_s2,
	output logic                                 axial_s2,
	output logic [bps_pkg::SIDE_BITS-1:0]        ax_side_s2
);
	import bps_pkg::*;

	logic                  valid_s2;
	logic [SIDE_BITS-1:0]  ax_side;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	// axial plane: distance against the slab bounds
	always_comb begin
		priority if (dist_s1 <= ax_lo_s1) begin
			ax_side = SIDE_FRONT;
		end else if (dist_s1 >= ax_hi_s1) begin
			ax_side = SIDE_BACK;
		end else begin
			ax_side = SIDE_BOTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// one exact product per lane and corner
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < AXES; i++) begin
				pnear_s2[i] <= PW'(nrm_s1[i]) * PW'(near_s1[i]);
				pfar_s2[i]  <= PW'(nrm_s1[i]) * PW'(far_s1[i]);
			end
			dist_s2    <= dist_s1;
			axial_s2   <= axial_s1;
			ax_side_s2 <= ax_side;
		end
	end

endmodule

// ----- src/bps_sum.sv -----
module bps_sum #(
	parameter int COORD_BITS = bps_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = bps_pkg::NORMAL_FRAC_BITS_DEF,
	localparam int PW = COORD_BITS + bps_pkg::NORMAL_BITS,
	localparam int SW = PW + 2,
	localparam int DW = COORD_BITS + NORMAL_FRAC_BITS + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [PW-1:0]          pnear_s2 [bps_pkg::AXES],
	input  logic signed [PW-1:0]          pfar_s2 [bps_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]  dist_s2,
	input  logic                          axial_s2,
	input  logic [bps_pkg::SIDE_BITS-1:0] ax_side_s2,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SW-1:0]          dnear_s3,
	output logic signed [SW-1:0]          dfar_s3,
	output logic signed [DW-1:0]          dshift_s3,
	output logic                          axial_s3,
	output logic [bps_pkg::SIDE_BITS-1:0] ax_side_s3
);
	import bps_pkg::*;

	logic valid_s3;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// three-term dot products and the distance at product scale
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dnear_s3   <= SW'(pnear_s2[0]) + SW'(pnear_s2[1]) + SW'(pnear_s2[2]);
			dfar_s3    <= SW'(pfar_s2[0]) + SW'(pfar_s2[1]) + SW'(pfar_s2[2]);
			dshift_s3  <= DW'(dist_s2) <<< NORMAL_FRAC_BITS;
			axial_s3   <= axial_s2;
			ax_side_s3 <= ax_side_s2;
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import bps_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_ITEMS = 400;
	localparam logic [KIND_BITS-1:0] KIND_GENERAL_LAST = 3'd7;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [15:0] NORMAL_ONE = 16'sd16384;

	typedef struct {
		logic signed [31:0] min_x, min_y, min_z;
		logic signed [31:0] max_x, max_y, max_z;
		logic signed [15:0] normal_x, normal_y, normal_z;
		logic signed [31:0] plane_dist;
		logic [KIND_BITS-1:0] plane_kind;
		logic [AXES-1:0] sign_bits;
	} box_req_t;

	typedef struct {
		box_req_t req;
		logic [SIDE_BITS-1:0] sides;
	} side_expect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid;
	logic [SIDE_BITS-1:0] sides;
	box_req_t cur_req = '{default: '0};

	box_req_t box_requests_q[$];
	side_expect_t expected_sides_q[$];
	logic req_taken = 1'b0;
	int accepted_count = 0;
	int submitted_count = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	box_plane_side_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.min_x(cur_req.min_x),
		.min_y(cur_req.min_y),
		.min_z(cur_req.min_z),
		.max_x(cur_req.max_x),
		.max_y(cur_req.max_y),
		.max_z(cur_req.max_z),
		.normal_x(cur_req.normal_x),
		.normal_y(cur_req.normal_y),
		.normal_z(cur_req.normal_z),
		.plane_dist(cur_req.plane_dist),
		.plane_kind(cur_req.plane_kind),
		.sign_bits(cur_req.sign_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sides(sides)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// expected sides of a box against a plane, exact wide arithmetic
	function automatic logic [SIDE_BITS-1:0] classify_box(box_req_t r);
		logic signed [31:0] lo[3];
		logic signed [31:0] hi[3];
		logic signed [15:0] nrm[3];
		logic signed [127:0] near_dot, far_dot, dist_w, n_w, near_w, far_w;
		logic [SIDE_BITS-1:0] res;
		lo = '{r.min_x, r.min_y, r.min_z};
		hi = '{r.max_x, r.max_y, r.max_z};
		nrm = '{r.normal_x, r.normal_y, r.normal_z};
		// axial plane: compare distance with the box extent on that axis
		if (r.plane_kind < AXIAL_KINDS) begin
			if (r.plane_dist <= lo[r.plane_kind])
				return SIDE_FRONT;
			else if (r.plane_dist >= hi[r.plane_kind])
				return SIDE_BACK;
			return SIDE_BOTH;
		end
		// general plane: sign bits pick near and far corners
		near_dot = '0;
		far_dot = '0;
		for (int i = 0; i < AXES; i++) begin
			n_w = nrm[i];
			near_w = r.sign_bits[i] ? lo[i] : hi[i];
			far_w = r.sign_bits[i] ? hi[i] : lo[i];
			near_dot = near_dot + n_w * near_w;
			far_dot = far_dot + n_w * far_w;
		end
		dist_w = r.plane_dist;
		dist_w = dist_w <<< NORMAL_FRAC_BITS_DEF;
		res = SIDE_NONE;
		if (near_dot >= dist_w)
			res = res | SIDE_FRONT;
		if (far_dot < dist_w)
			res = res | SIDE_BACK;
		return res;
	endfunction

	function automatic longint pick_between(longint a, longint b);
		longint t;
		longint unsigned span;
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		span = longint'(b - a) + 1;
		return a + longint'({$urandom, $urandom} % span);
	endfunction

	function automatic logic signed [31:0] random_coord(int unsigned shift);
		logic signed [31:0] raw;
		raw = $urandom;
		return raw >>> shift;
	endfunction

	// random box and plane, mostly consistent and near the box
	function automatic box_req_t make_random_req();
		box_req_t r;
		logic signed [31:0] lo[3];
		logic signed [31:0] hi[3];
		logic signed [15:0] nrm[3];
		logic signed [31:0] a, b, t;
		logic [AXES-1:0] sb;
		logic [KIND_BITS-1:0] kind;
		int unsigned shift, sel, ax;
		longint acc;
		sel = $urandom_range(0, 9);
		shift = (sel == 0) ? 0 : (sel < 6) ? 12 : 20;
		for (int i = 0; i < AXES; i++) begin
			a = random_coord(shift);
			b = random_coord(shift);
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			// occasional inverted box
			if ($urandom_range(0, 15) == 0) begin
				t = a;
				a = b;
				b = t;
			end
			lo[i] = a;
			hi[i] = b;
			if ($urandom_range(0, 19) == 0)
				nrm[i] = $urandom;
			else
				nrm[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
		end
		// axis-aligned normal on a general plane
		if ($urandom_range(0, 7) == 0) begin
			ax = $urandom_range(0, 2);
			nrm = '{16'sd0, 16'sd0, 16'sd0};
			nrm[ax] = $urandom_range(0, 1) ? NORMAL_ONE : -NORMAL_ONE;
		end
		for (int i = 0; i < AXES; i++)
			sb[i] = nrm[i] < 0;
		if ($urandom_range(0, 9) == 0)
			sb = $urandom;
		if ($urandom_range(0, 4) < 2)
			kind = $urandom_range(0, 2);
		else
			kind = $urandom_range(AXIAL_KINDS, KIND_GENERAL_LAST);
		// distance placed around the box
		if (kind < AXIAL_KINDS) begin
			sel = $urandom_range(0, 7);
			if (sel == 0)
				r.plane_dist = lo[kind];
			else if (sel == 1)
				r.plane_dist = hi[kind];
			else
				r.plane_dist = 32'(pick_between(longint'(lo[kind]) - 64,
					longint'(hi[kind]) + 64));
		end else begin
			acc = 0;
			for (int i = 0; i < AXES; i++)
				acc = acc + longint'(nrm[i]) * pick_between(lo[i], hi[i]);
			r.plane_dist = 32'((acc >>> NORMAL_FRAC_BITS_DEF) + pick_between(-256, 256));
			if ($urandom_range(0, 9) == 0)
				r.plane_dist = $urandom;
		end
		r.min_x = lo[0];
		r.min_y = lo[1];
		r.min_z = lo[2];
		r.max_x = hi[0];
		r.max_y = hi[1];
		r.max_z = hi[2];
		r.normal_x = nrm[0];
		r.normal_y = nrm[1];
		r.normal_z = nrm[2];
		r.plane_kind = kind;
		r.sign_bits = sb;
		return r;
	endfunction

	task automatic queue_req(box_req_t r);
		box_requests_q.push_back(r);
		submitted_count++;
	endtask

	task automatic add_req(input logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz,
		input logic signed [15:0] nx, ny, nz, input logic signed [31:0] pdist,
		input logic [KIND_BITS-1:0] kind, input logic [AXES-1:0] sb);
		box_req_t r;
		r = '{mnx, mny, mnz, mxx, mxy, mxz, nx, ny, nz, pdist, kind, sb};
		queue_req(r);
	endtask

	task automatic wait_accepted();
		while (accepted_count != submitted_count)
			@(posedge clk);
	endtask

	task automatic report_mismatch(string what, box_req_t r, logic [SIDE_BITS-1:0] want,
		logic [SIDE_BITS-1:0] got);
		$display("%0t mismatch: %s kind %0d dist %0d sign %b expected %b got %b", $time,
			what, r.plane_kind, r.plane_dist, r.sign_bits, want, got);
		mismatch_count++;
	endtask

	// request driver
	always @(negedge clk) begin
		box_req_t nxt;
		logic v;
		if (arst_n) begin
			nxt = cur_req;
			v = in_valid;
			if (!in_valid || req_taken) begin
				v = 1'b0;
				if (box_requests_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = box_requests_q.pop_front();
					v = 1'b1;
				end
			end
			in_valid <= v;
			cur_req <= nxt;
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		side_expect_t want;
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_sides_q.push_back('{cur_req, classify_box(cur_req)});
				accepted_count <= accepted_count + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_sides_q.size() == 0) begin
					report_mismatch("result with no request pending", cur_req, SIDE_NONE, sides);
				end else begin
					want = expected_sides_q.pop_front();
					if (sides !== want.sides)
						report_mismatch("sides", want.req, want.sides, sides);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// axial planes: on min, on max, inside, outside
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, -256, KIND_X, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 256, KIND_X, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 0, KIND_X, 3'b111);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, -1000, KIND_Y, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 512, KIND_Y, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 5, KIND_Z, 3'b000);
		// axial plane with inverted box
		add_req(10, 10, 10, -10, -10, -10, 0, 0, 0, 0, KIND_Z, 3'b000);
		// axial extremes
		add_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			-16'sd32768, 16'sd32767, 0, COORD_MIN, KIND_X, 3'b101);
		add_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			16'sd32767, -16'sd32768, -1, COORD_MAX, KIND_Z, 3'b010);
		// general plane: straddle, front only on far equality, both on near equality, back only
		add_req(-256, -256, -256, 256, 256, 256, NORMAL_ONE, 0, 0, 0, AXIAL_KINDS, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, NORMAL_ONE, 0, 0, -256, AXIAL_KINDS, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, NORMAL_ONE, 0, 0, 256, AXIAL_KINDS, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, NORMAL_ONE, 0, 0, 257, 3'd4, 3'b000);
		// general plane, inverted box gives no side
		add_req(100, 100, 100, -100, -100, -100, NORMAL_ONE, 0, 0, 0, 3'd5, 3'b000);
		// sign bits disagreeing with the normal
		add_req(-256, -256, -256, 256, 256, 256, -NORMAL_ONE, 0, 0, 0, 3'd6, 3'b000);
		// zero normal against zero and positive distance
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 0, KIND_GENERAL_LAST, 3'b000);
		add_req(-256, -256, -256, 256, 256, 256, 0, 0, 0, 1, KIND_GENERAL_LAST, 3'b111);
		// extreme coordinates and normals outside the unit range
		add_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			-16'sd32768, -16'sd32768, -16'sd32768, COORD_MIN, KIND_GENERAL_LAST, 3'b111);
		add_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			NORMAL_ONE, NORMAL_ONE, NORMAL_ONE, COORD_MAX, 3'd4, 3'b000);
		add_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			16'sd32767, 16'sd32767, 16'sd32767, COORD_MIN, AXIAL_KINDS, 3'b000);
		add_req(-1000, 2000, -3000, 4000, 5000, 6000, 16'sd9000, -16'sd12000, 16'sd5000,
			-77, 3'd5, 3'b010);
		wait_accepted();

		// random phases: no idling, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 21 : 0;
			recv_stall_pct = (phase == 2) ? 79 : (phase == 3) ? 21 : 0;
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_req(make_random_req());
			wait_accepted();
		end

		while (expected_sides_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/bps_pkg.sv
src/bps_select.sv
src/bps_mult.sv
src/bps_sum.sv
src/box_plane_side_top.sv
test/tb.sv
